// ===== rtl/pphash_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pphash_pkg: shared types and constants of the prefix polynomial hash table
// widths, request and status codes, register indexes and the control bundle
// of the shared modular reduction unit
// ----------------------------------------------------------------------------
package pphash_pkg;

  // string store
  localparam int unsigned MAX_CHARS = 1024;
  localparam int unsigned ADDR_W    = $clog2(MAX_CHARS);
  localparam int unsigned LEN_W     = $clog2(MAX_CHARS + 1);
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned BYTE_W    = 8;

  // hash arithmetic
  localparam int unsigned HASH_W    = 31;
  localparam int unsigned PROD_W    = 2 * HASH_W;
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned OFF_W     = HASH_W + 7;

  // radix-4 reduction: two dividend bits retired per step
  localparam int unsigned RED_LONG_STEPS  = DIV_W / 2;
  localparam int unsigned RED_SHORT_STEPS = DIV_W / 4;
  localparam int unsigned RED_STEP_W      = $clog2(RED_LONG_STEPS);

  // register reset values
  localparam logic [HASH_W-1:0] BASE_RESET = HASH_W'(31);
  localparam logic [HASH_W-1:0] MOD_RESET  = HASH_W'(257);

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    REG_BASE = 1'b0,
    REG_MOD  = 1'b1
  } reg_e;

  typedef struct packed {
    logic start;     // load dividend and modulus, begin stepping
    logic short_op;  // dividend holds only its upper half
  } red_ctl_t;

endpackage

// ===== rtl/pphash_modred.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pphash_modred: shared iterative modular reduction unit
// reduces a 64-bit dividend, or only its upper half, modulo a 31-bit modulus, two bits per cycle
// ----------------------------------------------------------------------------
module pphash_modred import pphash_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  red_ctl_t          ctl_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [HASH_W-1:0] modulus_i,
  output logic              done_o,
  output logic [HASH_W-1:0] result_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [RED_STEP_W-1:0] cnt_q;
  logic [DIV_W-1:0]      div_q;
  logic [HASH_W-1:0]     rem_q;
  logic [HASH_W-1:0]     m1_q;
  logic [HASH_W:0]       m2_q;
  logic [HASH_W+1:0]     m3_q;
  logic [HASH_W+1:0]     trial;
  logic [HASH_W+1:0]     rem_d;

  // remainder stays below m, so trial stays below 4m
  always_comb begin
    trial = {rem_q, div_q[DIV_W-1 -: 2]};
    if (trial >= m3_q) begin
      rem_d = trial - m3_q;
    end else if (trial >= {1'b0, m2_q}) begin
      rem_d = trial - {1'b0, m2_q};
    end else if (trial >= {2'b00, m1_q}) begin
      rem_d = trial - {2'b00, m1_q};
    end else begin
      rem_d = trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctl_i.short_op ? RED_STEP_W'(RED_SHORT_STEPS - 1)
                                 : RED_STEP_W'(RED_LONG_STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q - RED_STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      div_q <= dividend_i;
      rem_q <= '0;
      m1_q  <= modulus_i;
      m2_q  <= {modulus_i, 1'b0};
      m3_q  <= {1'b0, modulus_i, 1'b0} + {2'b00, modulus_i};
    end else if (busy_q) begin
      div_q <= div_q << 2;
      rem_q <= rem_d[HASH_W-1:0];
    end
  end

  assign done_o   = done_q;
  assign result_o = rem_q;

  // a finished residue is always fully reduced
  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < m1_q))
    else $error("reduction result not below modulus");

  // the sequencer never restarts the unit mid-reduction
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q)
    else $error("reduction started while busy");

  // completion comes in the cycle after the last step
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && $past(busy_q)))
    else $error("done without a finishing step");

endmodule

// ===== rtl/prefix_polynomial_hash_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_polynomial_hash_table_top: polynomial rolling hash store
// appends bytes to a string, keeps prefix hashes and base powers per
// position and answers substring hash queries modulo a programmable modulus
// ----------------------------------------------------------------------------
//
//  channel  handshake              payload
//  -------  ---------------------  ------------------------------------------
//  in       in_valid_i/in_ready_o  req_type_i, char_byte_i, left_index_i,
//                                  right_index_i
//  out      out_valid_o/out_ready_i hash_value_o, status_o, string_length_o
//  cfg      apb psel/penable/pwrite paddr, pwdata, prdata (base @0, mod @4)
//
//  an append runs two reductions of a 62-bit product
//  through the single radix-4 modular reduction unit (32 steps each)
//  a valid query runs one 32-step and one 16-step reduction
//  full, range error, clear and unused requests bypass the reduction unit
//  reset empties the string and loads base 31 and modulus 257
//  a finished item waits in the output register, the next item is taken
//  meanwhile; a new result only waits when that register is still full
//
module prefix_polynomial_hash_table_top import pphash_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [BYTE_W-1:0] char_byte_i,
  input  logic [IDX_W-1:0]  left_index_i,
  input  logic [IDX_W-1:0]  right_index_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [HASH_W-1:0] hash_value_o,
  output logic [1:0]        status_o,
  output logic [LEN_W-1:0]  string_length_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // sequencer states, one-hot
  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_AMUL   = 14'b00000000000010,  // hash * base
    S_ARED   = 14'b00000000000100,  // start hash reduction
    S_AWAIT  = 14'b00000000001000,
    S_PMUL   = 14'b00000000010000,  // power * base
    S_PRED   = 14'b00000000100000,  // start power reduction
    S_PWAIT  = 14'b00000001000000,
    S_QRDA   = 14'b00000010000000,  // read h[l] and pow[r-l+1]
    S_QRDB   = 14'b00000100000000,  // read h[r+1], multiply
    S_QRED1  = 14'b00001000000000,
    S_QWAIT1 = 14'b00010000000000,
    S_QRED2  = 14'b00100000000000,  // final short reduction
    S_QWAIT2 = 14'b01000000000000,
    S_OUT    = 14'b10000000000000   // hand result to output register
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [HASH_W-1:0] base_q;
  logic [HASH_W-1:0] mod_q;
  logic [HASH_W-1:0] m_eff;
  logic [HASH_W-1:0] m_minus1;

  // string state
  logic [LEN_W-1:0]  len_q;
  logic [HASH_W-1:0] rh_q;
  logic [HASH_W-1:0] rp_q;

  // item registers
  logic [IDX_W-1:0]  l_q;
  logic [IDX_W-1:0]  r_q;
  logic [OFF_W-1:0]  off_q;
  logic [PROD_W-1:0] product_q;
  logic [HASH_W-1:0] a_q;
  logic [HASH_W:0]   y_q;
  logic [HASH_W-1:0] res_hash_q;
  status_e           res_status_q;

  // output register
  logic              out_valid_q;
  logic [HASH_W-1:0] out_hash_q;
  logic [1:0]        out_status_q;
  logic [LEN_W-1:0]  out_len_q;

  // prefix hash and power stores, entry i+1 held at address i
  logic [HASH_W-1:0] ph_mem [MAX_CHARS];
  logic [HASH_W-1:0] bp_mem [MAX_CHARS];
  logic [HASH_W-1:0] ph_rd_q;
  logic [HASH_W-1:0] bp_rd_q;
  logic [ADDR_W-1:0] ph_raddr;
  logic [ADDR_W-1:0] bp_raddr;
  logic [ADDR_W-1:0] wr_addr;
  logic              ph_we;
  logic              bp_we;

  // shared multiplier and reduction unit
  logic [HASH_W-1:0] mul_a;
  logic [HASH_W-1:0] mul_b;
  red_ctl_t          red_ctl;
  logic [DIV_W-1:0]  red_dividend;
  logic              red_done;
  logic [HASH_W-1:0] red_result;

  // sequencer decode
  logic              accept;
  logic              res_load;
  logic [HASH_W-1:0] res_hash_d;
  status_e           res_status_d;
  logic              str_clear;
  logic              out_load;
  logic [OFF_W-1:0]  off_d;

  // modulus zero behaves as modulus one
  assign m_eff    = (mod_q == '0) ? HASH_W'(1) : mod_q;
  assign m_minus1 = m_eff - HASH_W'(1);

  // byte - 96 folded in as byte + 96*(m-1), congruent mod m and never negative
  assign off_d = OFF_W'({m_minus1, 6'b0}) + OFF_W'({m_minus1, 5'b0})
               + OFF_W'(char_byte_i);

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_BASE: prdata = {1'b0, base_q};
      REG_MOD:  prdata = {1'b0, mod_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
      mod_q  <= MOD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_e'(paddr[2]))
        REG_BASE: base_q <= pwdata[HASH_W-1:0];
        REG_MOD:  mod_q  <= pwdata[HASH_W-1:0];
        default:  ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    res_load     = 1'b0;
    res_hash_d   = '0;
    res_status_d = ST_OK;
    str_clear    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_e'(req_type_i))
            REQ_APPEND: begin
              if (len_q >= LEN_W'(MAX_CHARS)) begin
                res_load     = 1'b1;
                res_status_d = ST_FULL;
                state_d      = S_OUT;
              end else begin
                state_d = S_AMUL;
              end
            end
            REQ_QUERY: begin
              if ((left_index_i > right_index_i) ||
                  (LEN_W'(right_index_i) >= len_q)) begin
                res_load     = 1'b1;
                res_status_d = ST_RANGE;
                state_d      = S_OUT;
              end else begin
                state_d = S_QRDA;
              end
            end
            REQ_CLEAR: begin
              str_clear = 1'b1;
              res_load  = 1'b1;
              state_d   = S_OUT;
            end
            default: begin
              // unused request: no change, zero hash
              res_load = 1'b1;
              state_d  = S_OUT;
            end
          endcase
        end
      end
      S_AMUL:  state_d = S_ARED;
      S_ARED:  state_d = S_AWAIT;
      S_AWAIT: begin
        if (red_done) begin
          state_d = S_PMUL;
        end
      end
      S_PMUL:  state_d = S_PRED;
      S_PRED:  state_d = S_PWAIT;
      S_PWAIT: begin
        if (red_done) begin
          res_load   = 1'b1;
          res_hash_d = rh_q;
          state_d    = S_OUT;
        end
      end
      S_QRDA:  state_d = S_QRDB;
      S_QRDB:  state_d = S_QRED1;
      S_QRED1: state_d = S_QWAIT1;
      S_QWAIT1: begin
        if (red_done) begin
          state_d = S_QRED2;
        end
      end
      S_QRED2: state_d = S_QWAIT2;
      S_QWAIT2: begin
        if (red_done) begin
          res_load   = 1'b1;
          res_hash_d = red_result;
          state_d    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state: sequencer, string length, running hash and power, output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      rh_q        <= '0;
      rp_q        <= HASH_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (str_clear) begin
        len_q <= '0;
        rh_q  <= '0;
        rp_q  <= HASH_W'(1);
      end
      if ((state_q == S_AWAIT) && red_done) begin
        rh_q <= red_result;
      end
      if ((state_q == S_PWAIT) && red_done) begin
        rp_q  <= red_result;
        len_q <= len_q + LEN_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      l_q   <= left_index_i;
      r_q   <= right_index_i;
      off_q <= off_d;
    end
    product_q <= mul_a * mul_b;
    if (state_q == S_QRED1) begin
      a_q <= ph_rd_q;
    end
    // h[r+1] + (m - b), reduced once more below
    if ((state_q == S_QWAIT1) && red_done) begin
      y_q <= {1'b0, a_q} + {1'b0, m_eff - red_result};
    end
    if (res_load) begin
      res_hash_q   <= res_hash_d;
      res_status_q <= res_status_d;
    end
    if (out_load) begin
      out_hash_q   <= res_hash_q;
      out_status_q <= res_status_q;
      out_len_q    <= len_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hash_value_o    = out_hash_q;
  assign status_o        = out_status_q;
  assign string_length_o = out_len_q;

  // ---------------------------------------------------------------------------
  // hash stores
  // ---------------------------------------------------------------------------
  assign ph_raddr = (state_q == S_QRDB) ? ADDR_W'(r_q)
                                        : ADDR_W'(l_q - IDX_W'(1));
  assign bp_raddr = ADDR_W'(r_q - l_q);
  assign wr_addr  = len_q[ADDR_W-1:0];
  assign ph_we    = (state_q == S_AWAIT) && red_done;
  assign bp_we    = (state_q == S_PWAIT) && red_done;

  always_ff @(posedge clk_i) begin
    if (ph_we) begin
      ph_mem[wr_addr] <= red_result;
    end
    ph_rd_q <= ph_mem[ph_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bp_we) begin
      bp_mem[wr_addr] <= red_result;
    end
    bp_rd_q <= bp_mem[bp_raddr];
  end

  // ---------------------------------------------------------------------------
  // shared arithmetic
  // ---------------------------------------------------------------------------
  always_comb begin
    case (state_q)
      S_PMUL: begin
        mul_a = rp_q;
        mul_b = base_q;
      end
      S_QRDB: begin
        // h[0] is zero and lives outside the store
        mul_a = (l_q == '0) ? '0 : ph_rd_q;
        mul_b = bp_rd_q;
      end
      default: begin
        mul_a = rh_q;
        mul_b = base_q;
      end
    endcase
  end

  always_comb begin
    red_ctl.start    = (state_q == S_ARED) || (state_q == S_PRED) ||
                       (state_q == S_QRED1) || (state_q == S_QRED2);
    red_ctl.short_op = (state_q == S_QRED2);
    case (state_q)
      S_ARED:  red_dividend = DIV_W'(product_q) + DIV_W'(off_q);
      S_QRED2: red_dividend = {y_q, {(DIV_W - HASH_W - 1){1'b0}}};
      default: red_dividend = DIV_W'(product_q);
    endcase
  end

  pphash_modred u_modred (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (red_ctl),
    .dividend_i (red_dividend),
    .modulus_i  (m_eff),
    .done_o     (red_done),
    .result_o   (red_result)
  );

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_CHARS))
    else $error("string length beyond store depth");

  a_append_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AMUL) |-> (len_q < LEN_W'(MAX_CHARS)))
    else $error("append started on a full store");

  a_error_zero_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != 2'(ST_OK))) |-> (hash_value_o == '0))
    else $error("error item carries a nonzero hash");

  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_PWAIT) && red_done) |=> (len_q == $past(len_q) + LEN_W'(1)))
    else $error("append did not advance the length by one");

endmodule

// ===== bench/prefix_polynomial_hash_table_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_polynomial_hash_table_top_test: self-checking bench of the hash store
// drives appends, substring queries, clears and unused requests under several
// base/modulus settings and idle patterns, predicts every result in a
// scoreboard class and compares it field by field as it leaves the block
// ----------------------------------------------------------------------------
module prefix_polynomial_hash_table_top_test import pphash_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned HOLD_CYCLES = 600;   // long receiver hold-off
  localparam int unsigned TAIL_CYCLES = 150;   // idle tail after the last result
  localparam int unsigned MIX_ITEMS   = 45;
  localparam int unsigned NUM_PHASES  = 12;
  localparam int unsigned FILL_PHASE  = 5;
  localparam int unsigned PRESS_PHASE = 4;
  localparam longint unsigned CODE_OFFSET = 96;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [HASH_W-1:0] hash;
    status_e           status;
    logic [LEN_W-1:0]  len;
  } hash_result_t;

  // predicted string store and the queue of results still owed by the block
  class hash_scoreboard;
    longint unsigned base_reg, mod_reg;
    longint unsigned prefix_tab [0:MAX_CHARS];
    longint unsigned power_tab  [0:MAX_CHARS];
    int unsigned     length;
    longint unsigned run_hash, run_pow;
    hash_result_t    awaited[$];
    int unsigned     errors;

    function new();
      base_reg      = 64'(BASE_RESET);
      mod_reg       = 64'(MOD_RESET);
      prefix_tab[0] = 0;
      power_tab[0]  = 1;
      length        = 0;
      run_hash      = 0;
      run_pow       = 1;
      errors        = 0;
    endfunction

    function void write_reg(reg_e idx, logic [31:0] value);
      if (idx == REG_BASE) begin
        base_reg = 64'(value[HASH_W-1:0]);
      end else begin
        mod_reg = 64'(value[HASH_W-1:0]);
      end
    endfunction

    function logic [31:0] read_reg(reg_e idx);
      return (idx == REG_BASE) ? 32'(base_reg) : 32'(mod_reg);
    endfunction

    function longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                      longint unsigned m);
      return ((a % m) * (b % m)) % m;
    endfunction

    function hash_result_t hash_request(logic [1:0] req, logic [BYTE_W-1:0] chr,
                                        logic [IDX_W-1:0] l, logic [IDX_W-1:0] r);
      longint unsigned m, code, a, b;
      int unsigned     li, ri;
      hash_result_t    res;
      m  = (mod_reg == 0) ? 64'd1 : mod_reg;
      li = 32'(l);
      ri = 32'(r);
      res.hash   = '0;
      res.status = ST_OK;
      case (req)
        REQ_APPEND: begin
          if (length >= MAX_CHARS) begin
            res.status = ST_FULL;
          end else begin
            code = 64'(chr);
            // bytes below the offset give a negative code, folded back into 0..m-1
            if (code >= CODE_OFFSET) begin
              code = (code - CODE_OFFSET) % m;
            end else begin
              code = (m - ((CODE_OFFSET - code) % m)) % m;
            end
            run_hash = (mul_mod(run_hash, base_reg, m) + code) % m;
            run_pow  = mul_mod(run_pow, base_reg, m);
            length++;
            prefix_tab[length] = run_hash;
            power_tab[length]  = run_pow;
            res.hash = HASH_W'(run_hash);
          end
        end
        REQ_QUERY: begin
          if (li > ri || ri >= length) begin
            res.status = ST_RANGE;
          end else begin
            // stored entries may predate a modulus change, so reduce again
            a = prefix_tab[ri + 1] % m;
            b = mul_mod(prefix_tab[li], power_tab[ri - li + 1], m);
            res.hash = HASH_W'((a + m - b) % m);
          end
        end
        REQ_CLEAR: begin
          length   = 0;
          run_hash = 0;
          run_pow  = 1;
        end
        default: begin
        end
      endcase
      res.len = LEN_W'(length);
      return res;
    endfunction

    function void note_request(logic [1:0] req, logic [BYTE_W-1:0] chr,
                               logic [IDX_W-1:0] l, logic [IDX_W-1:0] r);
      awaited.push_back(hash_request(req, chr, l, r));
    endfunction

    function void check_result(logic [HASH_W-1:0] hash, logic [1:0] st,
                               logic [LEN_W-1:0] len);
      hash_result_t exp_res;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: hash_value %0d status %0d string_length %0d",
               hash, st, len);
        errors++;
        return;
      end
      exp_res = awaited.pop_front();
      if (hash !== exp_res.hash) begin
        $error("hash_value: expected %0d, actual %0d", exp_res.hash, hash);
        errors++;
      end
      if (st !== exp_res.status) begin
        $error("status: expected %0d, actual %0d", exp_res.status, st);
        errors++;
      end
      if (len !== exp_res.len) begin
        $error("string_length: expected %0d, actual %0d", exp_res.len, len);
        errors++;
      end
    endfunction
  endclass

  // block signals, all inputs known from time zero
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [1:0]        req_type_i    = '0;
  logic [BYTE_W-1:0] char_byte_i   = '0;
  logic [IDX_W-1:0]  left_index_i  = '0;
  logic [IDX_W-1:0]  right_index_i = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [HASH_W-1:0] hash_value_o;
  logic [1:0]        status_o;
  logic [LEN_W-1:0]  string_length_o;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [2:0]        paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;

  // idle pattern knobs; gap_pct and stall_pct change only between phases
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned send_calm   = 0;
  int unsigned cycle_count = 0;
  logic        hold_toggle = 1'b0;  // flipped to start a long receiver hold-off

  hash_scoreboard hash_sb;

  prefix_polynomial_hash_table_top uut (.*);

  always #1 clk_i = ~clk_i;

  // idle cycles before the next item; stretches of back-to-back items too
  function automatic int unsigned draw_gap();
    int unsigned n;
    n = 0;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(8, 30);
    if ($urandom_range(0, 99) < gap_pct) begin
      // now and then a long gap, so the input idles across a whole computation
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 90);
      end else begin
        n = 1;
        while ($urandom_range(0, 99) < gap_pct) n++;
      end
    end
    return n;
  endfunction

  // offer one item and hold it until the block takes it; valid only drops in a gap
  task automatic send_item(input logic [1:0] req, input logic [BYTE_W-1:0] chr,
                           input logic [IDX_W-1:0] li, input logic [IDX_W-1:0] ri);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    char_byte_i   <= chr;
    left_index_i  <= li;
    right_index_i <= ri;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    hash_sb.note_request(req, chr, li, ri);
  endtask

  // unused fields of each request carry random noise
  task automatic append_char(input int unsigned chr);
    send_item(REQ_APPEND, BYTE_W'(chr), IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic query_range(input int unsigned l, input int unsigned r);
    send_item(REQ_QUERY, BYTE_W'($urandom), IDX_W'(l), IDX_W'(r));
  endtask

  task automatic clear_string();
    send_item(REQ_CLEAR, BYTE_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
  endtask

  // stop offering and wait until every predicted result has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (hash_sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  // one apb transfer; psel stays up so transfers can follow back to back
  task automatic apb_cycle(input logic wr, input logic [2:0] addr,
                           input logic [31:0] data, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
  endtask

  // write both registers and read each back; only called with the block idle
  task automatic program_hash(input logic [31:0] base_val, input logic [31:0] mod_val);
    logic [31:0] rd;
    logic [31:0] value;
    reg_e        idx;
    for (int i = 0; i < 2; i++) begin
      idx   = reg_e'(i);
      value = (idx == REG_BASE) ? base_val : mod_val;
      apb_cycle(1'b1, {idx, 2'b00}, value, rd);
      hash_sb.write_reg(idx, value);
      apb_cycle(1'b0, {idx, 2'b00}, '0, rd);
      if (rd !== hash_sb.read_reg(idx)) begin
        $error("prdata of register %0d: expected %0d, actual %0d",
               idx, hash_sb.read_reg(idx), rd);
        hash_sb.errors++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly appends and in-range queries, with broken ranges, clears and noise
  task automatic mixed_traffic(input int unsigned n, input bit clear_first);
    int unsigned pick, len, rr, ll;
    if (clear_first) clear_string();
    repeat (n) begin
      pick = $urandom_range(0, 99);
      len  = hash_sb.length;
      if (pick < 45) begin
        append_char($urandom_range(0, 255));
      end else if (pick < 80 && len > 0) begin
        rr = $urandom_range(0, len - 1);
        ll = $urandom_range(0, rr);
        query_range(ll, rr);
      end else if (pick < 88) begin
        query_range($urandom_range(0, 1023), $urandom_range(0, 1023));
      end else if (pick < 93 && len >= 2) begin
        ll = $urandom_range(1, len - 1);
        query_range(ll, $urandom_range(0, ll - 1));
      end else if (pick < 97) begin
        clear_string();
      end else begin
        send_item(REQ_UNUSED, BYTE_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
      end
    end
  endtask

  // fill the store to the last position, then knock on the full store
  task automatic fill_string();
    int unsigned rr;
    clear_string();
    while (hash_sb.length < MAX_CHARS) begin
      if (hash_sb.length > 0 && $urandom_range(0, 9) == 0) begin
        rr = $urandom_range(0, hash_sb.length - 1);
        query_range($urandom_range(0, rr), rr);
      end
      append_char($urandom_range(0, 255));
    end
    append_char(97);
    append_char(0);
    query_range(0, MAX_CHARS - 1);
    query_range(MAX_CHARS - 1, MAX_CHARS - 1);
    query_range(MAX_CHARS / 2, MAX_CHARS - 1);
    query_range(0, 0);
    append_char(255);
    clear_string();
  endtask

  // result side: check every accepted result, then pick the next ready level
  initial begin : result_sink
    int unsigned hold_left, stall_left, calm_left;
    logic        hold_seen;
    hold_left  = 0;
    stall_left = 0;
    calm_left  = 0;
    hold_seen  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        hash_sb.check_result(hash_value_o, status_o, string_length_o);
      end
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_ready_i <= 1'b1;
      end else begin
        if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(20, 100);
        if (stall_pct != 0 && $urandom_range(0, 99) == 0) stall_left = $urandom_range(10, 120);
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    hash_sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset settings: base 31, modulus 257
    query_range(0, 0);                          // query of the empty string
    append_char(97);                            // 'a' gives code 1
    append_char(96);                            // code 0
    append_char(0);                             // lowest byte, negative code
    append_char(255);                           // highest byte
    append_char(95);                            // code minus one
    query_range(0, 4);
    query_range(2, 2);
    query_range(1, 3);
    query_range(3, 1);                          // left above right
    query_range(5, 5);                          // right at the length
    query_range(MAX_CHARS - 1, MAX_CHARS - 1);  // top index, out of range
    send_item(REQ_UNUSED, '1, '1, '1);          // ignored request type
    clear_string();
    query_range(0, 0);                          // nothing left after clear
    append_char(122);
    append_char(1);
    // modulus changed with characters stored
    drain_results();
    program_hash(32'h7fff_ffff, 32'h7fff_ffff);
    query_range(0, 1);
    append_char(200);
    query_range(0, 2);
    // modulus zero acts as one
    drain_results();
    program_hash(31, 0);
    append_char(97);
    query_range(1, 3);
    // bit 31 of the write data is dropped by the 31-bit register
    drain_results();
    program_hash(32'hffff_ffff, 1);
    append_char(50);
    query_range(0, 4);

    // random phases, each with its own settings and idle pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        0:          program_hash(1, 2);
        1:          program_hash(32'h7fff_ffff, 32'h7fff_ffff);
        2:          program_hash(0, 1000003);
        3:          program_hash(12345, 1);
        FILL_PHASE: program_hash($urandom, 32'h7fff_ffff);
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            program_hash($urandom, $urandom_range(2, 5000));
          end else begin
            program_hash($urandom, $urandom);
          end
        end
      endcase
      gap_pct   = (p % 4 == 1) ? 69 : (p % 4 == 3) ? 10 : 0;
      stall_pct = (p % 4 == 2) ? 69 : (p % 4 == 3) ? 10 : 0;
      // receiver holds off while items keep coming, so the input backs up
      if (p == PRESS_PHASE) hold_toggle <= ~hold_toggle;
      if (p == FILL_PHASE) begin
        fill_string();
      end else begin
        mixed_traffic(MIX_ITEMS, $urandom_range(0, 1) == 1);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (hash_sb.errors == 0 && hash_sb.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
